>>> rtl/rtcbcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_pkg: shared types and constants
// Constants, command codes and controller/datapath handshake structs for the
// BCD calendar to seconds converter.
// ----------------------------------------------------------------------------
package rtcbcd_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned CenturyDays = 36525;

  // Reciprocal of 675 scaled by 2^35; with the count shifted right by 7 this
  // gives the exact day number for any 32-bit count.
  localparam logic [25:0] DayRecip = 26'd50903317;
  // Reciprocal of 7 scaled by 2^12, exact for day-of-year values below 512.
  localparam logic [9:0]  WeekRecip = 10'd586;

  // Command codes carried in the input beat.
  localparam logic CmdToCal  = 1'b0;
  localparam logic CmdToSecs = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input beat and start
    logic day_step;  // one step of the day number split
    logic tod_step;  // one step splitting the time of day
    logic year_step; // one year walk step
    logic mon_step;  // one month walk step
    logic fin_step;  // one final assembly step
    logic finish;    // register the result
  } rtcbcd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cmd;
    logic div_done;
    logic tod_done;
    logic year_done;
    logic mon_done;
    logic fin_done;
    logic early_out; // range or date error: end the conversion early
  } rtcbcd_sts_t;

  // Plain month length, month 1..12.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2:                          r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:       r = 5'd30;
      default:                       r = 5'd31;
    endcase
    return r;
  endfunction

  // Gregorian leap rule on years 2000..2199, given as offset from 2000.
  function automatic logic is_leap(input logic [7:0] yo);
    logic r;
    r = (yo[1:0] == 2'd0) && (yo != 8'd100);
    return r;
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] u;
    t = 4'd0;
    u = v;
    for (int i = 0; i < 9; i++) begin
      if (u >= 7'd10) begin
        u = u - 7'd10;
        t = t + 4'd1;
      end
    end
    return {t, u[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] r;
    r = ({4'd0, v[7:4]} << 3) + ({4'd0, v[7:4]} << 1) + {4'd0, v[3:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rtcbcd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_in_if / rtcbcd_out_if: valid/ready channels
// Input and result channels of the converter with their payload.
// ----------------------------------------------------------------------------
interface rtcbcd_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] count_seconds;
  logic [7:0]  second_code;
  logic [7:0]  minute_code;
  logic [7:0]  hour_code;
  logic [7:0]  day_code;
  logic [7:0]  month_code;
  logic [7:0]  year_code;
  modport source (output valid, command, count_seconds, second_code, minute_code,
                  hour_code, day_code, month_code, year_code, input ready);
  modport sink (input valid, command, count_seconds, second_code, minute_code,
                hour_code, day_code, month_code, year_code, output ready);
endinterface

interface rtcbcd_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] total_seconds;
  logic [6:0]  out_second;
  logic [6:0]  out_minute;
  logic [5:0]  out_hour;
  logic [5:0]  out_day;
  logic [4:0]  out_month;
  logic [7:0]  out_year;
  logic [2:0]  out_weekday;
  logic        date_invalid;
  logic        range_error;
  modport source (output valid, total_seconds, out_second, out_minute, out_hour,
                  out_day, out_month, out_year, out_weekday, date_invalid,
                  range_error, input ready);
  modport sink (input valid, total_seconds, out_second, out_minute, out_hour,
                out_day, out_month, out_year, out_weekday, date_invalid,
                range_error, output ready);
endinterface
`default_nettype wire

>>> rtl/rtcbcd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_dp: converter datapath
// Reciprocal multiply for the day number and the weekday, subtractive
// time-of-day split, year and month walks, and the shift-add accumulation of the seconds count.
// ----------------------------------------------------------------------------
module rtcbcd_dp (
  input  wire logic               clk,
  input  wire rtcbcd_pkg::rtcbcd_cmd_t cmd,
  output rtcbcd_pkg::rtcbcd_sts_t sts,
  input  wire logic               in_command,
  input  wire logic [31:0]        in_count_seconds,
  input  wire logic [7:0]         in_second_code,
  input  wire logic [7:0]         in_minute_code,
  input  wire logic [7:0]         in_hour_code,
  input  wire logic [7:0]         in_day_code,
  input  wire logic [7:0]         in_month_code,
  input  wire logic [7:0]         in_year_code,
  output logic [32:0]             res_total,
  output logic [6:0]              res_second,
  output logic [6:0]              res_minute,
  output logic [5:0]              res_hour,
  output logic [5:0]              res_day,
  output logic [4:0]              res_month,
  output logic [7:0]              res_year,
  output logic [2:0]              res_weekday,
  output logic                    res_invalid,
  output logic                    res_range
);

  logic        cmd_r;
  logic [31:0] quo_r;      // seconds count, then the day number
  logic [16:0] rem_r;      // time of day
  logic [5:0]  cnt_r;      // step counter
  logic [15:0] days_r;     // day number (to calendar) or day total (to seconds)
  logic [2:0]  wday_r;     // weekday of January 1 of the walked year
  logic [2:0]  wmod_r;     // day of year mod 7
  logic [7:0]  yr_r;       // year offset being walked
  logic [3:0]  mon_r;
  logic [5:0]  hh_r, mm_r, ss_r;
  logic [7:0]  sec_in_r, min_in_r, hr_in_r, day_in_r, mon_in_r, yr_in_r;
  logic        bad_r;
  logic [32:0] acc_r;

  logic [50:0] day_prod;
  logic [17:0] wk_prod;
  logic [5:0]  wk_quo;
  logic [8:0]  wk_rem;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        leap;
  logic [3:0]  dmod;
  logic [2:0]  wd_final;

  always_comb begin
    // Day number = ((count >> 7) * DayRecip) >> 35.
    day_prod = 51'(quo_r[31:7]) * 51'(rtcbcd_pkg::DayRecip);
    // Day of year mod 7 through the reciprocal of 7.
    wk_prod  = 18'(days_r[8:0]) * 18'(rtcbcd_pkg::WeekRecip);
    wk_quo   = wk_prod[17:12];
    wk_rem   = days_r[8:0] - ({3'd0, wk_quo} * 9'd7);
    leap  = rtcbcd_pkg::is_leap(yr_r);
    ylen  = leap ? 9'd366 : 9'd365;
    mlen  = rtcbcd_pkg::month_len(mon_r) + {4'd0, (mon_r == 4'd2) && leap};
  end

  // Main sequencing datapath.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      quo_r    <= in_count_seconds;
      rem_r    <= '0;
      cnt_r    <= '0;
      days_r   <= '0;
      wday_r   <= 3'd6;
      yr_r     <= '0;
      mon_r    <= 4'd1;
      hh_r     <= '0;
      mm_r     <= '0;
      ss_r     <= '0;
      acc_r    <= '0;
      sec_in_r <= rtcbcd_pkg::from_bcd(in_second_code);
      min_in_r <= rtcbcd_pkg::from_bcd(in_minute_code);
      hr_in_r  <= rtcbcd_pkg::from_bcd(in_hour_code);
      day_in_r <= rtcbcd_pkg::from_bcd(in_day_code);
      mon_in_r <= rtcbcd_pkg::from_bcd(in_month_code);
      yr_in_r  <= rtcbcd_pkg::from_bcd(in_year_code);
      bad_r    <= 1'b0;
    end else if (cmd.day_step) begin
      // First the day number, then the time of day as the count minus
      // whole days, taken modulo 2^17 since it lies below 86400.
      if (cnt_r == 6'd0) begin
        quo_r <= {16'd0, day_prod[50:35]};
        rem_r <= quo_r[16:0];
        cnt_r <= 6'd1;
      end else begin
        rem_r <= rem_r - (quo_r[16:0] * 17'(rtcbcd_pkg::SecsPerDay));
        cnt_r <= 6'd32;
      end
    end else if (cmd.tod_step) begin
      // Range check, then time of day split by subtraction, hours, minutes, seconds.
      if (cnt_r == 6'd32) begin
        days_r <= quo_r[15:0];
        bad_r  <= quo_r >= 32'(rtcbcd_pkg::CenturyDays);
        cnt_r  <= 6'd33;
      end else if (rem_r >= 17'd3600) begin
        rem_r <= rem_r - 17'd3600;
        hh_r  <= hh_r + 6'd1;
      end else if (rem_r >= 17'd60) begin
        rem_r <= rem_r - 17'd60;
        mm_r  <= mm_r + 6'd1;
      end else begin
        ss_r  <= rem_r[5:0];
        cnt_r <= 6'd34;
      end
    end else if (cmd.year_step) begin
      if (!cmd_r) begin
        // Weekday advances by the year length mod 7 along the walk.
        if (days_r >= {7'd0, ylen}) begin
          days_r <= days_r - {7'd0, ylen};
          yr_r   <= yr_r + 8'd1;
          if (leap) wday_r <= (wday_r >= 3'd5) ? wday_r - 3'd5 : wday_r + 3'd2;
          else wday_r <= (wday_r == 3'd6) ? 3'd0 : wday_r + 3'd1;
        end else begin
          wmod_r <= wk_rem[2:0];
          cnt_r  <= 6'd35;
        end
      end else begin
        if (cnt_r == 6'd0) begin
          // Load input year and month for the month length, range check, then walk years.
          yr_r  <= yr_in_r;
          mon_r <= mon_in_r[3:0];
          cnt_r <= 6'd1;
        end else if (cnt_r == 6'd1) begin
          bad_r <= (mon_in_r < 8'd1) || (mon_in_r > 8'd12) || (day_in_r < 8'd1) ||
                   (day_in_r > {3'd0, mlen}) || (hr_in_r > 8'd23) ||
                   (min_in_r > 8'd59) || (sec_in_r > 8'd59);
          yr_r  <= '0;
          mon_r <= 4'd1;
          cnt_r <= 6'd2;
        end else if (yr_r != yr_in_r) begin
          days_r <= days_r + {7'd0, ylen};
          yr_r   <= yr_r + 8'd1;
        end else begin
          cnt_r <= 6'd35;
        end
      end
    end else if (cmd.mon_step) begin
      if (!cmd_r) begin
        if (mon_r != 4'd12 && days_r >= {11'd0, mlen}) begin
          days_r <= days_r - {11'd0, mlen};
          mon_r  <= mon_r + 4'd1;
        end else begin
          cnt_r <= 6'd36;
        end
      end else begin
        if (mon_r != mon_in_r[3:0]) begin
          days_r <= days_r + {11'd0, mlen};
          mon_r  <= mon_r + 4'd1;
        end else begin
          days_r <= days_r + {8'd0, day_in_r} - 16'd1;
          cnt_r  <= 6'd36;
        end
      end
    end else if (cmd.fin_step) begin
      // For a seconds count, shift-add of days by 86400 = 2^16+2^14+2^12+2^8+2^7,
      // then the time of day.
      if (!cmd_r) begin
        cnt_r <= 6'd37;
      end else if (cnt_r == 6'd36) begin
        acc_r <= ({17'd0, days_r} << 16) + ({17'd0, days_r} << 14) +
                 ({17'd0, days_r} << 12);
        cnt_r <= 6'd38;
      end else if (cnt_r == 6'd38) begin
        acc_r <= acc_r + ({17'd0, days_r} << 8) + ({17'd0, days_r} << 7);
        cnt_r <= 6'd39;
      end else begin
        acc_r <= acc_r + 33'(hr_in_r) * 33'd3600 + 33'(min_in_r) * 33'd60 +
                 33'(sec_in_r);
        cnt_r <= 6'd37;
      end
    end
  end

  // Weekday: January 1 weekday plus the day of year mod 7, folded once.
  always_comb begin
    dmod     = {1'b0, wday_r} + {1'b0, wmod_r};
    wd_final = (dmod >= 4'd7) ? 3'(dmod - 4'd7) : dmod[2:0];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_total   <= '0;
      res_second  <= '0;
      res_minute  <= '0;
      res_hour    <= '0;
      res_day     <= '0;
      res_month   <= '0;
      res_year    <= '0;
      res_weekday <= '0;
      res_invalid <= 1'b0;
      res_range   <= 1'b0;
      if (!cmd_r) begin
        if (bad_r) begin
          res_range <= 1'b1;
        end else begin
          res_second  <= 7'(rtcbcd_pkg::to_bcd(7'(ss_r)));
          res_minute  <= 7'(rtcbcd_pkg::to_bcd(7'(mm_r)));
          res_hour    <= 6'(rtcbcd_pkg::to_bcd(7'(hh_r)));
          res_day     <= 6'(rtcbcd_pkg::to_bcd(7'(days_r[4:0]) + 7'd1));
          res_month   <= 5'(rtcbcd_pkg::to_bcd(7'(mon_r)));
          res_year    <= rtcbcd_pkg::to_bcd(yr_r[6:0]);
          res_weekday <= wd_final;
        end
      end else if (bad_r) begin
        res_invalid <= 1'b1;
      end else begin
        res_total <= acc_r;
      end
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.div_done  = (cnt_r == 6'd32);
  assign sts.tod_done  = (cnt_r == 6'd34);
  assign sts.year_done = (cnt_r == 6'd35);
  assign sts.mon_done  = (cnt_r == 6'd36);
  assign sts.fin_done  = (cnt_r == 6'd37);
  assign sts.early_out = bad_r;

endmodule
`default_nettype wire

>>> rtl/rtcbcd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_ctrl: converter controller
// Sequences the datapath phases and runs the input and result handshakes.
// ----------------------------------------------------------------------------
module rtcbcd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rtcbcd_pkg::rtcbcd_cmd_t cmd,
  input  wire rtcbcd_pkg::rtcbcd_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_TOD, ST_YEAR, ST_MON, ST_FIN, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.cmd) state_nxt = ST_YEAR;
        else if (sts.div_done) state_nxt = ST_TOD;
        else cmd.day_step = 1'b1;
      end
      ST_TOD: begin
        if (sts.tod_done) state_nxt = sts.early_out ? ST_OUT : ST_YEAR;
        else cmd.tod_step = 1'b1;
        if (sts.tod_done && sts.early_out) cmd.finish = 1'b1;
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          if (sts.early_out) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_MON;
          end
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MON: begin
        if (sts.mon_done) state_nxt = ST_FIN;
        else cmd.mon_step = 1'b1;
      end
      ST_FIN: begin
        if (sts.fin_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.fin_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready || !out_valid_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // State and registered valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new beat is taken once the previous result has left.
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_DIV) else $error("load did not start");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finish without valid");
`endif

endmodule
`default_nettype wire

>>> rtl/rtc_bcd_calendar_seconds_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_bcd_calendar_seconds_converter: BCD calendar <-> seconds since 2000
// Run time is set by the year and month walks and, to calendar, the time-of-day split.
// One beat at a time; the next beat can be taken in the cycle after the result leaves.
// Reset is synchronous, active low, and clears the controller only.
// ----------------------------------------------------------------------------
module rtc_bcd_calendar_seconds_converter (
  input wire logic clk,
  input wire logic rst_n,
  rtcbcd_in_if.sink    in_ch,
  rtcbcd_out_if.source out_ch
);

  rtcbcd_pkg::rtcbcd_cmd_t cmd;
  rtcbcd_pkg::rtcbcd_sts_t sts;
  logic in_ready;
  logic load_ok;

  assign in_ch.ready = in_ready;
  assign load_ok = in_ready;

  rtcbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid && load_ok),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rtcbcd_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_ch.command),
    .in_count_seconds (in_ch.count_seconds),
    .in_second_code   (in_ch.second_code),
    .in_minute_code   (in_ch.minute_code),
    .in_hour_code     (in_ch.hour_code),
    .in_day_code      (in_ch.day_code),
    .in_month_code    (in_ch.month_code),
    .in_year_code     (in_ch.year_code),
    .res_total        (out_ch.total_seconds),
    .res_second       (out_ch.out_second),
    .res_minute       (out_ch.out_minute),
    .res_hour         (out_ch.out_hour),
    .res_day          (out_ch.out_day),
    .res_month        (out_ch.out_month),
    .res_year         (out_ch.out_year),
    .res_weekday      (out_ch.out_weekday),
    .res_invalid      (out_ch.date_invalid),
    .res_range        (out_ch.range_error)
  );

endmodule
`default_nettype wire
